[rtl/fnc_pkg.sv]
package fnc_pkg;

    localparam int NUM_NOTES      = 81;
    localparam int FREQ_FRAC_BITS = 8;
    localparam int ROM_NOTES      = 81;
    localparam int IN_W           = 19;
    localparam int LOG_FRAC       = 24;
    localparam int HALF_CENTS     = 50;
    localparam int CENTS_MUL      = 1200;
    localparam int OUT_IDX_W      = 7;
    localparam int CENTS_W        = 7;

    localparam int NUM_EFF  = (NUM_NOTES > ROM_NOTES) ? ROM_NOTES : NUM_NOTES;
    localparam int IDX_W    = $clog2(NUM_EFF + 1);
    localparam int TAB_N    = 1 << IDX_W;
    localparam int BIT_W    = $clog2(IDX_W);
    localparam int NOTE_W   = 11 + FREQ_FRAC_BITS;
    localparam int CMP_W    = (NOTE_W > IN_W) ? NOTE_W : IN_W;
    localparam int TOP_W    = $clog2(NOTE_W);
    localparam int LOG_W    = TOP_W + LOG_FRAC;
    localparam int MANT_W   = 31;
    localparam int SQ_W     = 2 * MANT_W;
    localparam int SH_W     = $clog2(MANT_W);
    localparam int K_W      = $clog2(LOG_FRAC);
    localparam int PROD_W   = LOG_W + $clog2(CENTS_MUL + 1);
    localparam int Q_DEPTH  = 2;
    localparam int Q_PTR_W  = $clog2(Q_DEPTH);
    localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

    localparam int unsigned NOTE_MHZ [ROM_NOTES] = '{
        16351, 17324, 18354, 19445, 20601, 21827,
        23124, 24499, 25956, 27500, 29135, 30868,
        32703, 34648, 36708, 38891, 41203, 43654,
        46249, 48999, 51913, 55000, 58270, 61735,
        65406, 69296, 73416, 77782, 82407, 87307,
        92499, 97999, 103826, 110000, 116541, 123471,
        130813, 138591, 146832, 155563, 164814, 174614,
        184997, 195998, 207652, 220000, 233082, 246942,
        261626, 277183, 293665, 311127, 329628, 349228,
        369994, 391995, 415305, 440000, 466164, 493883,
        523251, 554365, 587330, 622254, 659255, 698456,
        739989, 783991, 830609, 880000, 932328, 987767,
        1046502, 1108731, 1174659, 1244508, 1318510, 1396913,
        1479978, 1567982, 1661219
    };

    typedef logic [CMP_W-1:0] t_note_tab [TAB_N];
    typedef logic [LOG_W-1:0] t_log_tab  [TAB_N];

    typedef struct packed {
        logic              ok;
        logic [IDX_W-1:0]  up;
        logic [NOTE_W-1:0] f;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic longint unsigned note_const(input int i);
        longint unsigned m;
        m = longint'(NOTE_MHZ[i]);
        return ((m << FREQ_FRAC_BITS) + 64'd500) / 1000;
    endfunction

    function automatic logic [LOG_W-1:0] log2_const(input longint unsigned v);
        longint unsigned m;
        longint unsigned r;
        int top;
        top = 0;
        for (int b = 0; b < 64; b++) begin
            if (v[b]) top = b;
        end
        if (top <= 30) m = v << (30 - top);
        else           m = v >> (top - 30);
        r = longint'(top) << LOG_FRAC;
        for (int k = LOG_FRAC - 1; k >= 0; k--) begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31)) begin
                r = r | (64'd1 << k);
                m = m >> 1;
            end
        end
        return LOG_W'(r);
    endfunction

    function automatic t_note_tab build_note_tab();
        t_note_tab t;
        for (int i = 0; i < TAB_N; i++) begin
            if (i < NUM_EFF) t[i] = CMP_W'(note_const(i));
            else             t[i] = '1;
        end
        return t;
    endfunction

    function automatic t_log_tab build_log_tab();
        t_log_tab t;
        for (int i = 0; i < TAB_N; i++) begin
            if (i < NUM_EFF) t[i] = log2_const(note_const(i));
            else             t[i] = '0;
        end
        return t;
    endfunction

    localparam t_note_tab NOTE_Q   = build_note_tab();
    localparam t_log_tab  NOTE_LOG = build_log_tab();

endpackage

[rtl/fnc_front.sv]
module fnc_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    input  logic [fnc_pkg::IN_W-1:0] i_freq_hz_q8,
    input  fnc_pkg::t_q_stat         i_q_stat,
    output logic                     busy,
    output logic                     o_push,
    output fnc_pkg::t_item           o_item
);
    import fnc_pkg::*;

    typedef enum logic [1:0] {F_IDLE, F_SRCH, F_PUSH} t_state;

    t_state             r_state;
    logic [CMP_W-1:0]   r_f;
    logic [IDX_W-1:0]   r_cnt;
    logic [BIT_W-1:0]   r_bit;
    logic [IDX_W-1:0]   cand;
    logic               cand_ok;

    always_comb begin
        cand    = r_cnt | (IDX_W'(1) << r_bit);
        cand_ok = (cand <= IDX_W'(NUM_EFF)) && (NOTE_Q[cand - IDX_W'(1)] <= r_f);
    end

    assign busy        = (r_state != F_IDLE);
    assign o_push      = (r_state == F_PUSH) && !i_q_stat.full;
    assign o_item.ok   = (r_cnt != '0) && (r_cnt != IDX_W'(NUM_EFF));
    assign o_item.up   = r_cnt;
    assign o_item.f    = NOTE_W'(r_f);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (start) begin
                        r_f     <= CMP_W'(i_freq_hz_q8);
                        r_cnt   <= '0;
                        r_bit   <= BIT_W'(IDX_W - 1);
                        r_state <= F_SRCH;
                    end
                end
                F_SRCH: begin
                    if (cand_ok) r_cnt <= cand;
                    if (r_bit == '0) r_state <= F_PUSH;
                    else             r_bit   <= r_bit - BIT_W'(1);
                end
                F_PUSH: begin
                    if (!i_q_stat.full) r_state <= F_IDLE;
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

[rtl/fnc_queue.sv]
module fnc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  fnc_pkg::t_item   i_item,
    input  logic             i_pop,
    output fnc_pkg::t_item   o_item,
    output fnc_pkg::t_q_stat o_stat
);
    import fnc_pkg::*;

    t_item               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wp;
    logic [Q_PTR_W-1:0]  r_rp;
    logic [Q_CNT_W-1:0]  r_cnt;

    assign o_item       = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + Q_PTR_W'(1);
            if (i_pop)  r_rp <= r_rp + Q_PTR_W'(1);
            r_cnt <= r_cnt + Q_CNT_W'(i_push) - Q_CNT_W'(i_pop);
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("queue pop while empty");
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> !o_stat.empty)
        else $error("queue empty after push");
`endif

endmodule

[rtl/fnc_back.sv]
module fnc_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  fnc_pkg::t_item                       i_item,
    input  fnc_pkg::t_q_stat                     i_q_stat,
    output logic                                 o_pop,
    output logic                                 o_valid,
    output logic                                 o_found,
    output logic [fnc_pkg::OUT_IDX_W-1:0]        o_note_index,
    output logic signed [fnc_pkg::CENTS_W-1:0]   o_cents_offset
);
    import fnc_pkg::*;

    typedef enum logic [2:0] {B_IDLE, B_NORM, B_ITER, B_DIFF, B_RND} t_state;

    localparam logic signed [CENTS_W-1:0] LOW_LIM = CENTS_W'(-HALF_CENTS);

    t_state                     r_state;
    logic [NOTE_W-1:0]          r_f;
    logic [IDX_W-1:0]           r_up;
    logic [MANT_W-1:0]          r_m;
    logic [LOG_W-1:0]           r_res;
    logic [K_W-1:0]             r_k;
    logic                       r_neg_up;
    logic                       r_neg_lo;
    logic [PROD_W-1:0]          r_p_up;
    logic [PROD_W-1:0]          r_p_lo;
    logic                       r_valid;
    logic                       r_found;
    logic [OUT_IDX_W-1:0]       r_idx;
    logic signed [CENTS_W-1:0]  r_cents;

    logic [TOP_W-1:0]           top;
    logic [MANT_W-1:0]          m_norm;
    logic [SQ_W-1:0]            sq;
    logic [MANT_W:0]            s;
    logic [MANT_W-1:0]          m_next;
    logic [LOG_W-1:0]           lr_up;
    logic [LOG_W-1:0]           lr_lo;
    logic                       neg_up;
    logic                       neg_lo;
    logic [LOG_W-1:0]           d_up;
    logic [LOG_W-1:0]           d_lo;
    logic signed [CENTS_W-1:0]  c_up;
    logic signed [CENTS_W-1:0]  c_lo;

    function automatic logic signed [CENTS_W-1:0] to_cents(input logic [PROD_W-1:0] p,
                                                            input logic neg);
        logic [PROD_W-1:0]  mag_full;
        logic [CENTS_W-1:0] mag;
        mag_full = (p + PROD_W'(1 << (LOG_FRAC - 1))) >> LOG_FRAC;
        mag      = (mag_full > PROD_W'(64)) ? CENTS_W'(64) : CENTS_W'(mag_full);
        if (neg)                    return CENTS_W'(0) - mag;
        else if (mag > CENTS_W'(63)) return CENTS_W'(63);
        else                        return mag;
    endfunction

    always_comb begin
        top = '0;
        for (int b = 0; b < NOTE_W; b++) begin
            if (r_f[b]) top = TOP_W'(b);
        end
        m_norm = MANT_W'({{(MANT_W - NOTE_W){1'b0}}, r_f} << (SH_W'(MANT_W - 1) - SH_W'(top)));
        sq     = SQ_W'(r_m) * SQ_W'(r_m);
        s      = sq[SQ_W-1:MANT_W-1];
        m_next = s[MANT_W] ? s[MANT_W:1] : s[MANT_W-1:0];
        lr_up  = NOTE_LOG[r_up];
        lr_lo  = NOTE_LOG[r_up - IDX_W'(1)];
        neg_up = (r_res < lr_up);
        neg_lo = (r_res < lr_lo);
        d_up   = neg_up ? (lr_up - r_res) : (r_res - lr_up);
        d_lo   = neg_lo ? (lr_lo - r_res) : (r_res - lr_lo);
        c_up   = to_cents(r_p_up, r_neg_up);
        c_lo   = to_cents(r_p_lo, r_neg_lo);
    end

    assign o_pop          = (r_state == B_IDLE) && !i_q_stat.empty;
    assign o_valid        = r_valid;
    assign o_found        = r_found;
    assign o_note_index   = r_idx;
    assign o_cents_offset = r_cents;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                B_IDLE: begin
                    if (!i_q_stat.empty) begin
                        if (i_item.ok) begin
                            r_f     <= i_item.f;
                            r_up    <= i_item.up;
                            r_state <= B_NORM;
                        end else begin
                            r_valid <= 1'b1;
                            r_found <= 1'b0;
                            r_idx   <= '0;
                            r_cents <= '0;
                        end
                    end
                end
                B_NORM: begin
                    r_m     <= m_norm;
                    r_res   <= LOG_W'(top) << LOG_FRAC;
                    r_k     <= K_W'(LOG_FRAC - 1);
                    r_state <= B_ITER;
                end
                B_ITER: begin
                    r_m <= m_next;
                    if (s[MANT_W]) r_res <= r_res | (LOG_W'(1) << r_k);
                    if (r_k == '0) r_state <= B_DIFF;
                    else           r_k     <= r_k - K_W'(1);
                end
                B_DIFF: begin
                    r_neg_up <= neg_up;
                    r_neg_lo <= neg_lo;
                    r_p_up   <= PROD_W'(d_up) * PROD_W'(CENTS_MUL);
                    r_p_lo   <= PROD_W'(d_lo) * PROD_W'(CENTS_MUL);
                    r_state  <= B_RND;
                end
                B_RND: begin
                    r_valid <= 1'b1;
                    r_found <= 1'b1;
                    if (c_up < LOW_LIM) begin
                        r_idx   <= OUT_IDX_W'(r_up - IDX_W'(1));
                        r_cents <= c_lo;
                    end else begin
                        r_idx   <= OUT_IDX_W'(r_up);
                        r_cents <= c_up;
                    end
                    r_state <= B_IDLE;
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule

[rtl/frequency_to_note_cents_unit.sv]
// An item passes the front's 7-step note search and the two-item queue to the back; an
// out-of-range item is answered from the back's idle state, an in-range one after NORM,
// 24 squaring steps of log2, DIFF and RND. The front accepts new items while the back
// works, and stays busy while the queue is full. Results cannot stall.
// Reset (synchronous, active low) empties the queue and idles both parts; no table clear.
module frequency_to_note_cents_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    input  logic [fnc_pkg::IN_W-1:0]             i_freq_hz_q8,
    output logic                                 busy,
    output logic                                 o_valid,
    output logic                                 o_found,
    output logic [fnc_pkg::OUT_IDX_W-1:0]        o_note_index,
    output logic signed [fnc_pkg::CENTS_W-1:0]   o_cents_offset
);
    import fnc_pkg::*;

    t_item   push_item;
    t_item   pop_item;
    t_q_stat q_stat;
    logic    push;
    logic    pop;

    fnc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_freq_hz_q8 (i_freq_hz_q8),
        .i_q_stat     (q_stat),
        .busy         (busy),
        .o_push       (push),
        .o_item       (push_item)
    );

    fnc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (pop_item),
        .o_stat  (q_stat)
    );

    fnc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (pop_item),
        .i_q_stat       (q_stat),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .o_found        (o_found),
        .o_note_index   (o_note_index),
        .o_cents_offset (o_cents_offset)
    );

endmodule

[bench/fnc_checker.sv]
module fnc_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic                                 i_busy,
    input  logic [fnc_pkg::IN_W-1:0]             i_freq_hz_q8,
    input  logic                                 i_valid,
    input  logic                                 i_found,
    input  logic [fnc_pkg::OUT_IDX_W-1:0]        i_note_index,
    input  logic signed [fnc_pkg::CENTS_W-1:0]   i_cents_offset,
    output int                                   o_fail_count,
    output int                                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PITCH_ROM = 81;
    localparam int PITCH_USED = (fnc_pkg::NUM_NOTES > PITCH_ROM) ? PITCH_ROM : fnc_pkg::NUM_NOTES;
    localparam int LOG_BITS = 24;
    localparam int REPORT_MAX = 10;

    localparam int unsigned PITCH_MHZ [PITCH_ROM] = '{
        16351, 17324, 18354, 19445, 20601, 21827,
        23124, 24499, 25956, 27500, 29135, 30868,
        32703, 34648, 36708, 38891, 41203, 43654,
        46249, 48999, 51913, 55000, 58270, 61735,
        65406, 69296, 73416, 77782, 82407, 87307,
        92499, 97999, 103826, 110000, 116541, 123471,
        130813, 138591, 146832, 155563, 164814, 174614,
        184997, 195998, 207652, 220000, 233082, 246942,
        261626, 277183, 293665, 311127, 329628, 349228,
        369994, 391995, 415305, 440000, 466164, 493883,
        523251, 554365, 587330, 622254, 659255, 698456,
        739989, 783991, 830609, 880000, 932328, 987767,
        1046502, 1108731, 1174659, 1244508, 1318510, 1396913,
        1479978, 1567982, 1661219
    };

    typedef struct packed {
        logic                                found;
        logic [fnc_pkg::OUT_IDX_W-1:0]       note_index;
        logic signed [fnc_pkg::CENTS_W-1:0]  cents;
    } t_note_cents;

    t_note_cents pitch_results_q[$];
    t_note_cents want;
    int          fails = 0;

    function automatic longint unsigned pitch_q8(input int idx);
        longint unsigned mhz;
        mhz = PITCH_MHZ[idx];
        return ((mhz << fnc_pkg::FREQ_FRAC_BITS) + 64'd500) / 64'd1000;
    endfunction

    function automatic longint unsigned log2_q24(input longint unsigned v);
        longint unsigned mant;
        longint unsigned acc;
        int              msb;
        msb = 0;
        while ((v >> (msb + 1)) != 0) msb++;
        mant = (msb <= 30) ? (v << (30 - msb)) : (v >> (msb - 30));
        acc = 64'(msb) << LOG_BITS;
        for (int k = LOG_BITS - 1; k >= 0; k--) begin
            mant = (mant * mant) >> 30;
            if (mant >= (64'd1 << 31)) begin
                acc = acc | (64'd1 << k);
                mant = mant >> 1;
            end
        end
        return acc;
    endfunction

    function automatic int cents_from(input longint unsigned f, input longint unsigned base);
        longint unsigned lf;
        longint unsigned lb;
        longint unsigned span;
        longint unsigned mag;
        logic            flat;
        lf = log2_q24(f);
        lb = log2_q24(base);
        flat = lf < lb;
        span = flat ? lb - lf : lf - lb;
        mag = (span * 64'd1200 + (64'd1 << (LOG_BITS - 1))) >> LOG_BITS;
        if (mag > 64) mag = 64;
        if (flat) return -int'(mag);
        return (mag > 63) ? 63 : int'(mag);
    endfunction

    function automatic t_note_cents predict_note(input logic [fnc_pkg::IN_W-1:0] freq);
        t_note_cents     res;
        longint unsigned f;
        int              pick;
        res = '0;
        f = freq;
        if (f < pitch_q8(0)) return res;
        for (int i = 1; i < PITCH_USED; i++) begin
            if (f < pitch_q8(i)) begin
                pick = i;
                if (cents_from(f, pitch_q8(i)) < -50) pick = i - 1;
                res.found = 1'b1;
                res.note_index = fnc_pkg::OUT_IDX_W'(pick);
                res.cents = fnc_pkg::CENTS_W'(cents_from(f, pitch_q8(pick)));
                return res;
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid) begin
                if (pitch_results_q.size() == 0) begin
                    if (fails < REPORT_MAX)
                        $display("unexpected result: found=%0d note=%0d cents=%0d",
                                 i_found, i_note_index, i_cents_offset);
                    fails = fails + 1;
                end else begin
                    want = pitch_results_q.pop_front();
                    if (i_found !== want.found || i_note_index !== want.note_index ||
                        i_cents_offset !== want.cents) begin
                        if (fails < REPORT_MAX)
                            $display("mismatch: expected found=%0d note=%0d cents=%0d,",
                                     want.found, want.note_index, want.cents,
                                     " got found=%0d note=%0d cents=%0d",
                                     i_found, i_note_index, i_cents_offset);
                        fails = fails + 1;
                    end
                end
            end
            if (i_start && !i_busy)
                pitch_results_q.push_back(predict_note(i_freq_hz_q8));
        end
        o_fail_count <= fails;
        o_pending <= pitch_results_q.size();
    end

endmodule

[bench/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fnc_pkg::*;

    localparam int RANDOM_ITEMS = 880;
    localparam int QUIET_TAIL = 150;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 120;
    localparam int FREQ_MAX = (1 << IN_W) - 1;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        start = 1'b0;
    logic [IN_W-1:0]             i_freq_hz_q8 = '0;
    logic                        busy;
    logic                        o_valid;
    logic                        o_found;
    logic [OUT_IDX_W-1:0]        o_note_index;
    logic signed [CENTS_W-1:0]   o_cents_offset;
    int                          fail_count;
    int                          pending_count;
    int                          cycles = 0;
    int                          plan[$];

    frequency_to_note_cents_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_freq_hz_q8   (i_freq_hz_q8),
        .busy           (busy),
        .o_valid        (o_valid),
        .o_found        (o_found),
        .o_note_index   (o_note_index),
        .o_cents_offset (o_cents_offset)
    );

    fnc_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_freq_hz_q8   (i_freq_hz_q8),
        .i_valid        (o_valid),
        .i_found        (o_found),
        .i_note_index   (o_note_index),
        .i_cents_offset (o_cents_offset),
        .o_fail_count   (fail_count),
        .o_pending      (pending_count)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int note_q(input int idx);
        longint unsigned mhz;
        mhz = NOTE_MHZ[idx];
        return int'(((mhz << FREQ_FRAC_BITS) + 64'd500) / 64'd1000);
    endfunction

    function automatic int half_step_up(input int idx);
        return $rtoi(real'(note_q(idx)) * (2.0 ** (1.0 / 24.0)));
    endfunction

    function automatic int random_freq();
        int pick;
        int idx;
        int lowest;
        int highest;
        pick = $urandom_range(0, 99);
        lowest = note_q(0);
        highest = note_q(NUM_EFF - 1);
        idx = $urandom_range(0, NUM_EFF - 2);
        if (pick < 55) return $urandom_range(note_q(idx + 1) - 1, note_q(idx));
        if (pick < 70) return note_q(idx + 1) + $urandom_range(0, 6) - 3;
        if (pick < 80) return half_step_up(idx) + $urandom_range(0, 8) - 4;
        if (pick < 88) return $urandom_range(lowest - 1, 0);
        if (pick < 95) return $urandom_range(FREQ_MAX, highest);
        return $urandom() & FREQ_MAX;
    endfunction

    task automatic send_freq(input int f);
        start <= 1'b1;
        i_freq_hz_q8 <= IN_W'(f);
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic hold_off(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    initial begin
        plan = '{0, 1, note_q(0) - 1, note_q(0), note_q(0) + 1, note_q(9), note_q(21),
                 note_q(57), note_q(30) - 1, note_q(NUM_EFF - 1) - 1, note_q(NUM_EFF - 1),
                 note_q(NUM_EFF - 1) + 1, FREQ_MAX, 'h2AAAA, 'h55555};
        foreach (plan[i]) ;
        for (int d = -1; d <= 1; d++) begin
            plan.push_back(half_step_up(10) + d);
            plan.push_back(half_step_up(50) + d);
            plan.push_back(half_step_up(NUM_EFF - 2) + d);
        end
        for (int n = 0; n < RANDOM_ITEMS; n++) plan.push_back(random_freq());

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[n]) begin
            if (n < plan.size() - QUIET_TAIL && $urandom_range(0, 9) < 3)
                hold_off($urandom_range(1, 19));
            send_freq(plan[n]);
        end
        start <= 1'b0;

        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
